FILE: hdl/tbps_pkg.sv
// Shared types and constants for the text/bitmap pixel sequencer.
`default_nettype none

package tbps_pkg;

  // Stream word widths (whole bytes)
  localparam int InWordW  = 32;
  localparam int OutWordW = 8;
  localparam int ItemW    = 29;

  localparam int NumBg    = 4;
  localparam int NumPal   = 4;
  localparam int CfgIdxW  = 2;

  localparam logic [3:0] BitsFull = 4'd8;

  typedef logic [3:0] color_t;

  // Graphics mode bits: ECM, BMM, MCM from high to low
  typedef enum logic [2:0] {
    MODE_TEXT       = 3'd0,
    MODE_MC_TEXT    = 3'd1,
    MODE_BITMAP     = 3'd2,
    MODE_MC_BITMAP  = 3'd3,
    MODE_ECM        = 3'd4,
    MODE_ECM_MC     = 3'd5,
    MODE_ECM_BMM    = 3'd6,
    MODE_ECM_BMM_MC = 3'd7
  } mode_t;

  // One input pixel, last-declared field in the lowest bits
  typedef struct packed {
    logic [7:0] fetched_char;
    color_t     fetched_color;
    logic [7:0] fetched_pixels;
    logic       clear_mc_flop;
    logic       update_colors;
    logic       shift_enable;
    logic       load_now;
    logic       mcm_now;
    mode_t      graphics_mode;
    logic       vertical_border;
  } pix_in_t;

  // One output pixel
  typedef struct packed {
    logic   is_foreground;
    color_t pixel_color;
  } pix_out_t;

  // Background register write
  typedef struct packed {
    logic               we;
    logic [CfgIdxW-1:0] index;
    color_t             data;
  } cfg_wr_t;

endpackage

`default_nettype wire

FILE: hdl/tbps_core.sv
// Sequencer state, palette selection and per-pixel color generation.
`default_nettype none

module tbps_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tbps_pkg::cfg_wr_t cfg,
  input  wire logic              step,
  input  wire tbps_pkg::pix_in_t pix,
  output tbps_pkg::pix_out_t     res
);
  import tbps_pkg::*;

  // Background registers and sequencer state
  color_t     bg_color [NumBg];
  color_t     palette [NumPal];
  logic [7:0] shift_data;
  logic [7:0] latched_char;
  color_t     latched_color;
  logic       mc_flop;
  logic [1:0] color_index;
  logic [3:0] bits_left;

  color_t     palette_next [NumPal];
  logic [7:0] shift_data_next;
  logic [7:0] latched_char_next;
  color_t     latched_color_next;
  logic       mc_flop_next;
  logic [1:0] color_index_next;
  logic [3:0] bits_left_next;

  logic       load;
  logic       refill;
  logic [7:0] sd;
  logic       mc_cur;
  logic [3:0] bl;
  logic [1:0] ci_hold;
  logic       mc_char;
  logic       mc_disp;
  logic       mc_gen;
  logic       fg;

  // Background register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumBg; i++) bg_color[i] <= '0;
    end else if (cfg.we) begin
      bg_color[cfg.index] <= cfg.data;
    end
  end

  // Load, color select, palette fill and draw for one pixel
  always_comb begin
    load   = pix.load_now && pix.shift_enable;
    refill = pix.update_colors || load;

    sd                 = load ? pix.fetched_pixels : shift_data;
    latched_color_next = load ? pix.fetched_color  : latched_color;
    latched_char_next  = load ? pix.fetched_char   : latched_char;
    mc_cur             = load ? 1'b1 : (pix.clear_mc_flop ? 1'b0 : mc_flop);
    bl                 = load ? BitsFull : bits_left;
    ci_hold            = (bl == 4'd0) ? 2'd0 : color_index;

    mc_char = pix.graphics_mode[1] || latched_color_next[3];
    mc_disp = pix.graphics_mode[0] && mc_char;
    mc_gen  = pix.mcm_now && mc_char;

    // color selector
    if (mc_gen) begin
      if (mc_cur) begin
        color_index_next = mc_disp ? sd[7:6] : {1'b0, sd[7]};
      end else begin
        color_index_next = ci_hold;
      end
    end else begin
      color_index_next = mc_disp ? {sd[7], 1'b0} : {1'b0, sd[7]};
    end

    // palette reload by mode
    for (int i = 0; i < NumPal; i++) palette_next[i] = palette[i];
    if (refill) begin
      unique case (pix.graphics_mode)
        MODE_TEXT: begin
          palette_next[0] = bg_color[0];
          palette_next[1] = latched_color_next;
        end
        MODE_MC_TEXT: begin
          palette_next[0] = bg_color[0];
          if (latched_color_next[3]) begin
            palette_next[1] = bg_color[1];
            palette_next[2] = bg_color[2];
            palette_next[3] = {1'b0, latched_color_next[2:0]};
          end else begin
            palette_next[1] = latched_color_next;
          end
        end
        MODE_BITMAP: begin
          palette_next[0] = latched_char_next[3:0];
          palette_next[1] = latched_char_next[7:4];
        end
        MODE_MC_BITMAP: begin
          palette_next[0] = bg_color[0];
          palette_next[1] = latched_char_next[7:4];
          palette_next[2] = latched_char_next[3:0];
          palette_next[3] = latched_color_next;
        end
        MODE_ECM: begin
          palette_next[0] = bg_color[latched_char_next[7:6]];
          palette_next[1] = latched_color_next;
        end
        MODE_ECM_MC, MODE_ECM_BMM, MODE_ECM_BMM_MC: begin
          for (int i = 0; i < NumPal; i++) palette_next[i] = '0;
        end
      endcase
    end

    fg = mc_disp ? color_index_next[1] : (color_index_next != 2'd0);

    // end-of-pixel advance
    shift_data_next = {sd[6:0], 1'b0};
    mc_flop_next    = ~mc_cur;
    bits_left_next  = (bl == 4'd0) ? 4'd0 : bl - 4'd1;

    // border pixels show entry 0 and leave the state alone
    if (pix.vertical_border) begin
      res.pixel_color   = palette[0];
      res.is_foreground = 1'b0;
    end else begin
      res.pixel_color   = palette_next[color_index_next];
      res.is_foreground = fg;
    end
  end

  // State update, once per processed non-border pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumPal; i++) palette[i] <= '0;
      shift_data    <= '0;
      latched_char  <= '0;
      latched_color <= '0;
      mc_flop       <= 1'b0;
      color_index   <= '0;
      bits_left     <= '0;
    end else if (step && !pix.vertical_border) begin
      for (int i = 0; i < NumPal; i++) palette[i] <= palette_next[i];
      shift_data    <= shift_data_next;
      latched_char  <= latched_char_next;
      latched_color <= latched_color_next;
      mc_flop       <= mc_flop_next;
      color_index   <= color_index_next;
      bits_left     <= bits_left_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/text_bitmap_pixel_sequencer.sv
// An accepted word moves from the input register through the core to the result register
// when the output is free. Throughput: one pixel word per clock unless the output stalls;
// a stalled output holds one word, the input register holds one more, then s_tready drops.
// Rate is set by the combinational path from the input register through the sequencer core.
// Reset (rst, synchronous): empties both registers, clears background registers,
// palette and all sequencer state to zero.
`default_nettype none

module text_bitmap_pixel_sequencer (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // slave: vertical_border[0], graphics_mode[3:1], mcm_now[4], load_now[5],
  // shift_enable[6], update_colors[7], clear_mc_flop[8], fetched_pixels[16:9],
  // fetched_color[20:17], fetched_char[28:21], zeros[31:29]
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [tbps_pkg::InWordW-1:0]        s_tdata,
  // master: pixel_color[3:0], is_foreground[4], zeros[7:5]
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [tbps_pkg::OutWordW-1:0]            m_tdata,
  // background register writes
  input  wire logic                                cfg_we,
  input  wire logic [tbps_pkg::CfgIdxW-1:0]        cfg_index,
  input  wire tbps_pkg::color_t                    cfg_data
);
  import tbps_pkg::*;

  logic     in_valid;
  pix_in_t  in_item;
  logic     out_valid;
  pix_out_t out_item;
  pix_out_t res;
  logic     advance;
  cfg_wr_t  cfg;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign cfg      = '{we: cfg_we, index: cfg_index, data: cfg_data};

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= pix_in_t'(s_tdata[ItemW-1:0]);
    end
  end

  tbps_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (advance),
    .pix  (in_item),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OutWordW - $bits(pix_out_t)){1'b0}}, out_item};

endmodule

`default_nettype wire

FILE: hdl/tbps_checker.sv
// Port-level checks for the pixel sequencer, bound to the top level.
`default_nettype none

module tbps_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [tbps_pkg::OutWordW-1:0] m_tdata
);
  import tbps_pkg::*;

  // no word out right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  // input only backs up when the output is full and stalled
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with free output");

  // an accepted word reaches the output after the input and result registers
  a_flow: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> ##2 m_tvalid)
    else $error("accepted word did not reach the output");

  // pad bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OutWordW-1:$bits(pix_out_t)] == '0)
    else $error("nonzero pad bits in output word");

endmodule

bind text_bitmap_pixel_sequencer tbps_checker u_tbps_checker (.*);

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the text/bitmap pixel sequencer: directed and random pixel words.
module testbench;
  import tbps_pkg::*;

  localparam int HalfPeriod = 2;
  localparam int StallLimit = 3000;
  localparam int HoldCycles = 200;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InWordW-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutWordW-1:0] m_tdata;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  color_t              cfg_data = '0;

  text_bitmap_pixel_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HalfPeriod clk = ~clk;

  // Predictor state: background registers and sequencer registers
  color_t     bg_reg [NumBg];
  color_t     palette [NumPal];
  logic [7:0] shift_reg = '0;
  logic [7:0] char_reg = '0;
  color_t     color_reg = '0;
  logic       mc_flop = 1'b0;
  logic [1:0] color_sel = '0;
  logic [3:0] bits_left = '0;

  pix_out_t expected_pixels [$];
  int err_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int idle_cycles = 0;

  // Sender pacing
  bit pacing_on = 1'b0;
  int burst_left = 0;

  // Receiver hold-off request, taken over by the receiver process
  int rx_hold_req = 0;
  int rx_hold_left = 0;
  int rx_cycle = 0;

  initial begin
    for (int i = 0; i < NumBg; i++) bg_reg[i] = '0;
    for (int i = 0; i < NumPal; i++) palette[i] = '0;
  end

  task automatic report_error(input string what);
    $display("mismatch: %s", what);
    err_count++;
  endtask

  // Palette refill for the mode in effect
  function automatic void reload_palette(input mode_t mode);
    case (mode)
      MODE_TEXT: begin
        palette[0] = bg_reg[0];
        palette[1] = color_reg;
      end
      MODE_MC_TEXT: begin
        palette[0] = bg_reg[0];
        if (color_reg[3]) begin
          palette[1] = bg_reg[1];
          palette[2] = bg_reg[2];
          palette[3] = {1'b0, color_reg[2:0]};
        end else begin
          palette[1] = color_reg;
        end
      end
      MODE_BITMAP: begin
        palette[0] = char_reg[3:0];
        palette[1] = char_reg[7:4];
      end
      MODE_MC_BITMAP: begin
        palette[0] = bg_reg[0];
        palette[1] = char_reg[7:4];
        palette[2] = char_reg[3:0];
        palette[3] = color_reg;
      end
      MODE_ECM: begin
        palette[0] = bg_reg[char_reg[7:6]];
        palette[1] = color_reg;
      end
      default: begin
        // ECM with BMM or MCM: everything black
        for (int i = 0; i < NumPal; i++) palette[i] = '0;
      end
    endcase
  endfunction

  // Expected output of one pixel, advancing the predictor state
  function automatic pix_out_t predict_pixel(input pix_in_t p);
    pix_out_t r;
    logic upd, mc_char, mc_disp, mc_gen;
    r = '0;
    // border pixel: background entry 0, nothing else moves
    if (p.vertical_border) begin
      r.pixel_color = palette[0];
      r.is_foreground = 1'b0;
      return r;
    end
    upd = p.update_colors;
    if (p.clear_mc_flop) mc_flop = 1'b0;
    if (p.load_now && p.shift_enable) begin
      shift_reg = p.fetched_pixels;
      color_reg = p.fetched_color;
      char_reg = p.fetched_char;
      mc_flop = 1'b1;
      upd = 1'b1;
      bits_left = BitsFull;
    end
    if (bits_left == 0) color_sel = 2'd0;
    mc_char = p.graphics_mode[1] || color_reg[3];
    mc_disp = p.graphics_mode[0] && mc_char;
    mc_gen = p.mcm_now && mc_char;
    if (mc_gen) begin
      if (mc_flop) color_sel = mc_disp ? shift_reg[7:6] : {1'b0, shift_reg[7]};
    end else begin
      color_sel = mc_disp ? {shift_reg[7], 1'b0} : {1'b0, shift_reg[7]};
    end
    if (upd) reload_palette(p.graphics_mode);
    r.pixel_color = palette[color_sel];
    r.is_foreground = mc_disp ? color_sel[1] : (color_sel != 2'd0);
    shift_reg = {shift_reg[6:0], 1'b0};
    mc_flop = ~mc_flop;
    if (bits_left > 0) bits_left = bits_left - 1'b1;
    return r;
  endfunction

  function automatic pix_in_t make_pixel(input mode_t mode, input logic mcm, input logic load,
                                         input logic en, input logic upd, input logic clr,
                                         input logic [7:0] px, input color_t col,
                                         input logic [7:0] ch);
    pix_in_t p;
    p.vertical_border = 1'b0;
    p.graphics_mode = mode;
    p.mcm_now = mcm;
    p.load_now = load;
    p.shift_enable = en;
    p.update_colors = upd;
    p.clear_mc_flop = clr;
    p.fetched_pixels = px;
    p.fetched_color = col;
    p.fetched_char = ch;
    return p;
  endfunction

  // Offer one pixel word, wait for it to be taken, record its expected result
  task automatic send_pixel(input pix_in_t p);
    int gap;
    if (pacing_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    s_tdata <= InWordW'(p);
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    expected_pixels.push_back(predict_pixel(p));
    sent_count++;
  endtask

  // Stop offering and wait until every expected word is back
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four background registers; block must be idle
  task automatic set_backgrounds(input color_t c0, input color_t c1,
                                 input color_t c2, input color_t c3);
    color_t vals [NumBg];
    vals = '{c0, c1, c2, c3};
    for (int i = 0; i < NumBg; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= CfgIdxW'(i);
      cfg_data <= vals[i];
      bg_reg[i] = vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // State straight out of reset: no load yet, plus a border pixel
  task automatic test_reset_state();
    pix_in_t p;
    send_pixel(make_pixel(MODE_TEXT, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'hFF, 4'hF, 8'hFF));
    p = make_pixel(MODE_MC_BITMAP, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 4'h0, 8'h00);
    p.vertical_border = 1'b1;
    send_pixel(p);
    wait_drain();
  endtask

  // One load and one following pixel in each of the eight modes
  task automatic test_graphics_modes();
    mode_t m;
    set_backgrounds(4'h1, 4'h6, 4'hA, 4'hE);
    for (int i = 0; i < 8; i++) begin
      m = mode_t'(i);
      send_pixel(make_pixel(m, m[0], 1'b1, 1'b1, 1'b0, 1'b0, 8'hE4,
                            m[0] ? 4'hB : 4'h5, 8'hC7));
      send_pixel(make_pixel(m, m[0], 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 4'h0, 8'h00));
    end
    wait_drain();
  endtask

  // Border mid-cell, flop clear, load without enable, counter running dry
  task automatic test_special_cases();
    pix_in_t p;
    send_pixel(make_pixel(MODE_MC_BITMAP, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'hFF, 4'hF, 8'h00));
    p = make_pixel(MODE_MC_BITMAP, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 4'h0, 8'hFF);
    p.vertical_border = 1'b1;
    send_pixel(p);
    send_pixel(make_pixel(MODE_MC_BITMAP, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 4'h0, 8'h00));
    send_pixel(make_pixel(MODE_MC_BITMAP, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 4'h0, 8'h00));
    for (int i = 0; i < 6; i++)
      send_pixel(make_pixel(MODE_MC_BITMAP, 1'b1, 1'b0, 1'b0, i == 5, 1'b0,
                            8'h55, 4'h3, 8'h81));
    wait_drain();
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    pacing_on = 1'b0;
    rx_hold_req = HoldCycles;
    for (int i = 0; i < 40; i++)
      send_pixel(make_pixel(mode_t'($urandom_range(0, 4)), 1'($urandom_range(0, 1)),
                            (i % 8) == 0, 1'b1, 1'b0, 1'b0, 8'($urandom()),
                            4'($urandom()), 8'($urandom())));
    wait_drain();
  endtask

  // Character cells of random length with random content, plus raw noise words
  task automatic run_random_pixels(input int count);
    int sent_here;
    int cell_len;
    mode_t line_mode;
    pix_in_t p;
    sent_here = 0;
    line_mode = mode_t'($urandom_range(0, 7));
    while (sent_here < count) begin
      if ($urandom_range(0, 5) == 0) line_mode = mode_t'($urandom_range(0, 7));
      if ($urandom_range(0, 4) == 0) begin
        p = pix_in_t'(ItemW'($urandom()));
        send_pixel(p);
        sent_here++;
      end else begin
        cell_len = $urandom_range(1, 12);
        for (int i = 0; i < cell_len && sent_here < count; i++) begin
          p.graphics_mode = line_mode;
          p.mcm_now = ($urandom_range(0, 7) == 0) ? ~line_mode[0] : line_mode[0];
          p.load_now = (i == 0);
          p.shift_enable = (i == 0) ? ($urandom_range(0, 7) != 0) : 1'($urandom_range(0, 1));
          p.update_colors = ($urandom_range(0, 7) == 0);
          p.clear_mc_flop = ($urandom_range(0, 15) == 0);
          p.vertical_border = ($urandom_range(0, 19) == 0);
          p.fetched_pixels = 8'($urandom());
          p.fetched_color = 4'($urandom());
          p.fetched_char = 8'($urandom());
          send_pixel(p);
          sent_here++;
        end
      end
    end
    wait_drain();
  endtask

  // Random phases, each under its own background setting
  task automatic test_random_phases();
    pacing_on = 1'b1;
    set_backgrounds(4'h0, 4'h0, 4'h0, 4'h0);
    run_random_pixels(76);
    set_backgrounds(4'hF, 4'hF, 4'hF, 4'hF);
    run_random_pixels(76);
    set_backgrounds(4'h0, 4'hF, 4'h0, 4'hF);
    run_random_pixels(76);
    for (int k = 0; k < 2; k++) begin
      set_backgrounds(4'($urandom()), 4'($urandom()), 4'($urandom()), 4'($urandom()));
      run_random_pixels(76);
    end
    pacing_on = 1'b0;
  endtask

  // Receiver: long hold-off on request, otherwise a rotating stall pattern
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 64) % 4)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ((rx_cycle % 3) == 0);
        default: m_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Output check against the oldest expected word
  always @(posedge clk) begin : check_output
    pix_out_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = pix_out_t'(m_tdata[4:0]);
      if (expected_pixels.size() == 0) begin
        report_error($sformatf("unexpected output word %h", m_tdata));
      end else begin
        want = expected_pixels.pop_front();
        checked_count++;
        if (got.pixel_color !== want.pixel_color)
          report_error($sformatf("word %0d pixel_color %h, want %h",
                                 checked_count, got.pixel_color, want.pixel_color));
        if (got.is_foreground !== want.is_foreground)
          report_error($sformatf("word %0d is_foreground %b, want %b",
                                 checked_count, got.is_foreground, want.is_foreground));
        if (m_tdata[OutWordW-1:5] !== '0)
          report_error($sformatf("word %0d padding bits %h", checked_count, m_tdata));
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no word moved for %0d cycles", idle_cycles);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_graphics_modes();
    test_special_cases();
    test_backpressure();
    test_random_phases();
    wait_drain();
    repeat (10) @(posedge clk);
    if (expected_pixels.size() != 0)
      report_error($sformatf("%0d expected words never arrived", expected_pixels.size()));
    $display("summary: %0d pixel words sent, %0d checked, %0d mismatches",
             sent_count, checked_count, err_count);
    $display("summary: all eight modes, border, flop clear, counter run-out, hold-off, bursts");
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
